@@ hw/rtl/xxh32_pkg.sv @@
package xxh32_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    // Stream payload widths
    localparam int WORD_W    = 32;
    localparam int BCNT_W    = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    // Rotate and shift amounts of the hash
    localparam logic [4:0] ROT_NONE  = 5'd0;
    localparam logic [4:0] ROT_LANE  = 5'd13;
    localparam logic [4:0] ROT_WORD  = 5'd17;
    localparam logic [4:0] ROT_BYTE  = 5'd11;
    localparam logic [4:0] ROT_MRG0  = 5'd1;
    localparam logic [4:0] ROT_MRG1  = 5'd7;
    localparam logic [4:0] ROT_MRG2  = 5'd12;
    localparam logic [4:0] ROT_MRG3  = 5'd18;
    localparam logic [4:0] SHR_AV1   = 5'd15;
    localparam logic [4:0] SHR_AV2   = 5'd13;
    localparam logic [4:0] SHR_AV3   = 5'd16;

    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,   // a * prime
        OP_XSMUL  = 3'd1,   // (a ^ (a >> sh_a)) * prime
        OP_XS     = 3'd2,   // a ^ (a >> sh_a)
        OP_ADDROT = 3'd3,   // rotl(a + b, sh_a)
        OP_ROTADD = 3'd4    // rotl(a, sh_a) + rotl(b, sh_b)
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [4:0]  sh_a;
        logic [4:0]  sh_b;
        logic [31:0] prime;
    } alu_ctl_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        return (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

    // Lane start values for a given seed
    function automatic logic [31:0] lane_init(input logic [31:0] seed, input logic [1:0] i);
        logic [31:0] v;
        unique case (i)
            2'd0: v = seed + PRIME1 + PRIME2;
            2'd1: v = seed + PRIME2;
            2'd2: v = seed;
            2'd3: v = seed - PRIME1;
            default: v = seed;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/xxhash32_stream_unit.sv @@
// A non-final word is taken while idle; the fourth word of a stripe then runs 4 lane rounds
//   (multiply, add-rotate, multiply) through the single shared multiplier/adder unit.
// No beat is taken meanwhile. The final beat then runs those rounds if it closes a stripe,
//   start value, merge if one was absorbed, length, words, bytes, avalanche, held on stall.
// Reset (aresetn low, synchronous): seed 0, lanes loaded from seed 0, counts cleared,
//   output empty; no clearing pass, the unit is ready the cycle after reset is released.
module xxhash32_stream_unit #(
    parameter int LENGTH_BITS = xxh32_pkg::LENGTH_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic [xxh32_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,   // last_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] hash_value
    output logic [xxh32_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [31:0]                    cfg_data   // hash_seed
);
    import xxh32_pkg::*;

    // Sequencer states
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_LANE_M1 = 5'd1;
    localparam logic [4:0] ST_LANE_AR = 5'd2;
    localparam logic [4:0] ST_LANE_M2 = 5'd3;
    localparam logic [4:0] ST_FIN0    = 5'd4;
    localparam logic [4:0] ST_MRG1    = 5'd5;
    localparam logic [4:0] ST_MRG2    = 5'd6;
    localparam logic [4:0] ST_LEN     = 5'd7;
    localparam logic [4:0] ST_WRD_M1  = 5'd8;
    localparam logic [4:0] ST_WRD_AR  = 5'd9;
    localparam logic [4:0] ST_WRD_M2  = 5'd10;
    localparam logic [4:0] ST_BYT_M1  = 5'd11;
    localparam logic [4:0] ST_BYT_AR  = 5'd12;
    localparam logic [4:0] ST_BYT_M2  = 5'd13;
    localparam logic [4:0] ST_AV1     = 5'd14;
    localparam logic [4:0] ST_AV2     = 5'd15;
    localparam logic [4:0] ST_AV3     = 5'd16;

    // Control state
    logic [4:0]             state_reg, state_next;
    logic [1:0]             idx_reg, idx_next;
    logic [1:0]             nbuf_reg, nbuf_next;      // words waiting in the stripe buffer
    logic [1:0]             tail_reg, tail_next;      // trailing bytes of the final beat
    logic                   last_reg, last_next;
    logic                   long_reg, long_next;      // at least one stripe absorbed
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            seed_reg, seed_next;
    logic [31:0]            lane_reg [4];
    logic [31:0]            lane_next [4];
    logic                   m_tvalid_reg, m_tvalid_next;

    // Datapath registers, no reset needed
    logic [31:0]            buf_reg [4];
    logic [31:0]            word_reg, word_next;
    logic [31:0]            prod_reg, prod_next;
    logic [31:0]            tmp_reg, tmp_next;
    logic [31:0]            h_reg, h_next;
    logic [31:0]            m_tdata_reg, m_tdata_next;
    logic                   buf_we;

    // Shared unit
    alu_ctl_t               alu_ctl;
    logic [31:0]            alu_a;
    logic [31:0]            alu_b;
    logic [31:0]            alu_y;

    // Input beat decode
    logic [31:0]            in_word;
    logic [2:0]             in_raw;
    logic [2:0]             in_bc;
    logic                   in_full;
    logic [31:0]            len32;

    assign in_word = s_tdata[31:0];
    assign in_raw  = s_tdata[34:32];
    // Clamp oversized byte counts to a full word
    assign in_bc   = (in_raw > 3'd4) ? 3'd4 : in_raw;
    assign in_full = (in_bc == 3'd4);
    assign len32   = 32'(len_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    xxh32_alu u_alu (
        .ctl (alu_ctl),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y)
    );

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        nbuf_next     = nbuf_reg;
        tail_next     = tail_reg;
        last_next     = last_reg;
        long_next     = long_reg;
        len_next      = len_reg;
        seed_next     = seed_reg;
        for (int i = 0; i < 4; i++) begin
            lane_next[i] = lane_reg[i];
        end
        word_next     = word_reg;
        prod_next     = prod_reg;
        tmp_next      = tmp_reg;
        h_next        = h_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        buf_we        = 1'b0;

        alu_ctl = '{op: OP_ROTADD, sh_a: ROT_NONE, sh_b: ROT_NONE, prime: PRIME1};
        alu_a   = h_reg;
        alu_b   = prod_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // Seed write: reload lanes unless a stripe already touched them
                if (cfg_valid) begin
                    seed_next = cfg_data;
                    if (!long_reg) begin
                        for (int i = 0; i < 4; i++) begin
                            lane_next[i] = lane_init(cfg_data, 2'(i));
                        end
                    end
                end
                // Drop short non-final beats; take everything else
                if (s_tvalid && (s_tlast || in_full)) begin
                    len_next  = len_reg + {{(LENGTH_BITS-3){1'b0}}, in_bc};
                    word_next = in_word;
                    tail_next = in_full ? 2'd0 : in_bc[1:0];
                    last_next = s_tlast;
                    if (in_full) begin
                        buf_we = 1'b1;
                        if (nbuf_reg == 2'd3) begin
                            nbuf_next  = 2'd0;
                            long_next  = 1'b1;
                            idx_next   = 2'd0;
                            state_next = ST_LANE_M1;
                        end else begin
                            nbuf_next = nbuf_reg + 2'd1;
                            if (s_tlast) begin
                                state_next = ST_FIN0;
                            end
                        end
                    end else begin
                        state_next = ST_FIN0;
                    end
                end
            end

            // Lane round: acc = rotl(acc + w*P2, 13) * P1
            ST_LANE_M1: begin
                alu_ctl    = '{op: OP_MUL, sh_a: ROT_NONE, sh_b: ROT_NONE, prime: PRIME2};
                alu_a      = buf_reg[idx_reg];
                prod_next  = alu_y;
                state_next = ST_LANE_AR;
            end
            ST_LANE_AR: begin
                alu_ctl    = '{op: OP_ADDROT, sh_a: ROT_LANE, sh_b: ROT_NONE, prime: PRIME1};
                alu_a      = lane_reg[idx_reg];
                alu_b      = prod_reg;
                tmp_next   = alu_y;
                state_next = ST_LANE_M2;
            end
            ST_LANE_M2: begin
                alu_ctl            = '{op: OP_MUL, sh_a: ROT_NONE, sh_b: ROT_NONE,
                                       prime: PRIME1};
                alu_a              = tmp_reg;
                lane_next[idx_reg] = alu_y;
                idx_next           = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    state_next = last_reg ? ST_FIN0 : ST_IDLE;
                end else begin
                    state_next = ST_LANE_M1;
                end
            end

            // Start value: merged lanes, or seed + P5 for a short message
            ST_FIN0: begin
                if (long_reg) begin
                    alu_ctl    = '{op: OP_ROTADD, sh_a: ROT_MRG0, sh_b: ROT_MRG1,
                                   prime: PRIME1};
                    alu_a      = lane_reg[0];
                    alu_b      = lane_reg[1];
                    state_next = ST_MRG1;
                end else begin
                    alu_a      = seed_reg;
                    alu_b      = PRIME5;
                    state_next = ST_LEN;
                end
                h_next = alu_y;
            end
            ST_MRG1: begin
                alu_ctl    = '{op: OP_ROTADD, sh_a: ROT_MRG2, sh_b: ROT_MRG3, prime: PRIME1};
                alu_a      = lane_reg[2];
                alu_b      = lane_reg[3];
                tmp_next   = alu_y;
                state_next = ST_MRG2;
            end
            ST_MRG2: begin
                alu_a      = h_reg;
                alu_b      = tmp_reg;
                h_next     = alu_y;
                state_next = ST_LEN;
            end
            ST_LEN: begin
                alu_a    = h_reg;
                alu_b    = len32;
                h_next   = alu_y;
                idx_next = 2'd0;
                if (nbuf_reg != 2'd0) begin
                    state_next = ST_WRD_M1;
                end else if (tail_reg != 2'd0) begin
                    state_next = ST_BYT_M1;
                end else begin
                    state_next = ST_AV1;
                end
            end

            // Word tail: h = rotl(h + w*P3, 17) * P4
            ST_WRD_M1: begin
                alu_ctl    = '{op: OP_MUL, sh_a: ROT_NONE, sh_b: ROT_NONE, prime: PRIME3};
                alu_a      = buf_reg[idx_reg];
                prod_next  = alu_y;
                state_next = ST_WRD_AR;
            end
            ST_WRD_AR: begin
                alu_ctl    = '{op: OP_ADDROT, sh_a: ROT_WORD, sh_b: ROT_NONE, prime: PRIME1};
                alu_a      = h_reg;
                alu_b      = prod_reg;
                tmp_next   = alu_y;
                state_next = ST_WRD_M2;
            end
            ST_WRD_M2: begin
                alu_ctl  = '{op: OP_MUL, sh_a: ROT_NONE, sh_b: ROT_NONE, prime: PRIME4};
                alu_a    = tmp_reg;
                h_next   = alu_y;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == nbuf_reg - 2'd1) begin
                    idx_next   = 2'd0;
                    state_next = (tail_reg != 2'd0) ? ST_BYT_M1 : ST_AV1;
                end else begin
                    state_next = ST_WRD_M1;
                end
            end

            // Byte tail: h = rotl(h + b*P5, 11) * P1
            ST_BYT_M1: begin
                alu_ctl    = '{op: OP_MUL, sh_a: ROT_NONE, sh_b: ROT_NONE, prime: PRIME5};
                alu_a      = {24'd0, word_reg[8*idx_reg +: 8]};
                prod_next  = alu_y;
                state_next = ST_BYT_AR;
            end
            ST_BYT_AR: begin
                alu_ctl    = '{op: OP_ADDROT, sh_a: ROT_BYTE, sh_b: ROT_NONE, prime: PRIME1};
                alu_a      = h_reg;
                alu_b      = prod_reg;
                tmp_next   = alu_y;
                state_next = ST_BYT_M2;
            end
            ST_BYT_M2: begin
                alu_ctl  = '{op: OP_MUL, sh_a: ROT_NONE, sh_b: ROT_NONE, prime: PRIME1};
                alu_a    = tmp_reg;
                h_next   = alu_y;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == tail_reg - 2'd1) begin
                    state_next = ST_AV1;
                end else begin
                    state_next = ST_BYT_M1;
                end
            end

            // Avalanche
            ST_AV1: begin
                alu_ctl    = '{op: OP_XSMUL, sh_a: SHR_AV1, sh_b: ROT_NONE, prime: PRIME2};
                alu_a      = h_reg;
                h_next     = alu_y;
                state_next = ST_AV2;
            end
            ST_AV2: begin
                alu_ctl    = '{op: OP_XSMUL, sh_a: SHR_AV2, sh_b: ROT_NONE, prime: PRIME3};
                alu_a      = h_reg;
                h_next     = alu_y;
                state_next = ST_AV3;
            end
            ST_AV3: begin
                alu_ctl = '{op: OP_XS, sh_a: SHR_AV3, sh_b: ROT_NONE, prime: PRIME1};
                alu_a   = h_reg;
                // Hold here until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = alu_y;
                    m_tvalid_next = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        lane_next[i] = lane_init(seed_reg, 2'(i));
                    end
                    nbuf_next  = 2'd0;
                    len_next   = '0;
                    long_next  = 1'b0;
                    idx_next   = 2'd0;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 2'd0;
            nbuf_reg     <= 2'd0;
            tail_reg     <= 2'd0;
            last_reg     <= 1'b0;
            long_reg     <= 1'b0;
            len_reg      <= '0;
            seed_reg     <= '0;
            for (int i = 0; i < 4; i++) begin
                lane_reg[i] <= lane_init(32'd0, 2'(i));
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            nbuf_reg     <= nbuf_next;
            tail_reg     <= tail_next;
            last_reg     <= last_next;
            long_reg     <= long_next;
            len_reg      <= len_next;
            seed_reg     <= seed_next;
            for (int i = 0; i < 4; i++) begin
                lane_reg[i] <= lane_next[i];
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_reg[nbuf_reg] <= in_word;
        end
        word_reg    <= word_next;
        prod_reg    <= prod_next;
        tmp_reg     <= tmp_next;
        h_reg       <= h_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

@@ hw/rtl/xxh32_alu.sv @@
module xxh32_alu (
    input  xxh32_pkg::alu_ctl_t ctl,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output logic [31:0]         y
);
    import xxh32_pkg::*;

    logic [31:0] xs;
    logic [31:0] mul_in;
    logic [31:0] mul_lo;

    // One 32x32 multiplier, low half only
    assign xs     = a ^ (a >> ctl.sh_a);
    assign mul_in = (ctl.op == OP_XSMUL) ? xs : a;
    assign mul_lo = mul_in * ctl.prime;

    always_comb begin
        unique case (ctl.op)
            OP_MUL:    y = mul_lo;
            OP_XSMUL:  y = mul_lo;
            OP_XS:     y = xs;
            OP_ADDROT: y = rotl32(a + b, ctl.sh_a);
            OP_ROTADD: y = rotl32(a, ctl.sh_a) + rotl32(b, ctl.sh_b);
            default:   y = '0;
        endcase
    end

endmodule

@@ hw/rtl/xxh32_chk.sv @@
module xxh32_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_ready
);

    // A stalled hash beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("hash beat dropped or changed while stalled");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A hash never shows up the cycle after an input beat
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared directly after input beat");

    // When a hash appears the unit is already free for the next message
    a_ready_on_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (s_tready && cfg_ready))
        else $error("unit busy when hash appeared");

    // Seed writes and input beats are taken in the same phase
    a_cfg_with_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !cfg_ready)
        else $error("seed write open while a beat is in work");

endmodule

bind xxhash32_stream_unit xxh32_chk u_xxh32_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

@@ bench/xxh32_hash_checker.sv @@
`timescale 1ns / 1ps
module xxh32_hash_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [xxh32_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [xxh32_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [31:0]                     cfg_data,
    output int                              mismatch_count,
    output int                              hashes_due
);

    logic [31:0] seed_q;
    logic [31:0] lane_acc [4];
    logic [31:0] stripe_words [4];
    logic [31:0] byte_total;
    int          words_held;
    bit          stripe_seen;
    logic [31:0] expected_hashes [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] mix_lane(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] a;
        a = acc + w * xxh32_pkg::PRIME2;
        a = rol(a, 13);
        return a * xxh32_pkg::PRIME1;
    endfunction

    task automatic reload_lanes();
        lane_acc[0] = seed_q + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
        lane_acc[1] = seed_q + xxh32_pkg::PRIME2;
        lane_acc[2] = seed_q;
        lane_acc[3] = seed_q - xxh32_pkg::PRIME1;
    endtask

    task automatic clear_message();
        reload_lanes();
        words_held  = 0;
        byte_total  = '0;
        stripe_seen = 1'b0;
    endtask

    task automatic push_stripe_word(input logic [31:0] w);
        stripe_words[words_held] = w;
        if (words_held == 3) begin
            for (int i = 0; i < 4; i++)
                lane_acc[i] = mix_lane(lane_acc[i], stripe_words[i]);
            words_held  = 0;
            stripe_seen = 1'b1;
        end else begin
            words_held++;
        end
    endtask

    // Predict the effect of one accepted input beat
    task automatic take_beat(input logic [31:0] w, input logic [2:0] bc_raw, input logic last);
        int          bc;
        logic [31:0] h;
        bc = (bc_raw > 3'd4) ? 4 : int'(bc_raw);
        if (!last) begin
            // short words before the end are dropped
            if (bc == 4) begin
                byte_total += 32'd4;
                push_stripe_word(w);
            end
        end else begin
            byte_total += bc;
            if (bc == 4)
                push_stripe_word(w);
            if (stripe_seen)
                h = rol(lane_acc[0], 1) + rol(lane_acc[1], 7)
                  + rol(lane_acc[2], 12) + rol(lane_acc[3], 18);
            else
                h = seed_q + xxh32_pkg::PRIME5;
            h += byte_total;
            for (int i = 0; i < words_held; i++) begin
                h += stripe_words[i] * xxh32_pkg::PRIME3;
                h = rol(h, 17) * xxh32_pkg::PRIME4;
            end
            if (bc < 4) begin
                for (int i = 0; i < bc; i++) begin
                    h += {24'd0, w[8*i +: 8]} * xxh32_pkg::PRIME5;
                    h = rol(h, 11) * xxh32_pkg::PRIME1;
                end
            end
            h ^= h >> 15;
            h = h * xxh32_pkg::PRIME2;
            h ^= h >> 13;
            h = h * xxh32_pkg::PRIME3;
            h ^= h >> 16;
            expected_hashes.push_back(h);
            clear_message();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_q = '0;
            clear_message();
            expected_hashes.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                seed_q = cfg_data;
                if (!stripe_seen)
                    reload_lanes();
            end
            // compare before predicting: a result never stems from the same edge's beat
            if (m_tvalid && m_tready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: unexpected beat, actual %h", m_tdata);
                    mismatch_count++;
                end else if (m_tdata !== expected_hashes[0]) begin
                    $error("hash_value: expected %h, actual %h", expected_hashes[0], m_tdata);
                    mismatch_count++;
                    void'(expected_hashes.pop_front());
                end else begin
                    void'(expected_hashes.pop_front());
                end
            end
            if (s_tvalid && s_tready)
                take_beat(s_tdata[31:0], s_tdata[34:32], s_tlast);
        end
        hashes_due = expected_hashes.size();
    end

endmodule

@@ bench/tb_xxhash32_stream_unit.sv @@
`timescale 1ns / 1ps
module tb_xxhash32_stream_unit;

    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_BEATS   = 425;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic [xxh32_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tready  = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [31:0]                     cfg_data  = '0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [xxh32_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            cfg_ready;

    int send_idle  = 0;
    int recv_stall = 0;
    int beats_sent = 0;
    int mismatch_count;
    int hashes_due;

    xxhash32_stream_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    xxh32_hash_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .hashes_due    (hashes_due)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Offer one beat, idling first at random, and hold it until taken
    task automatic send_beat(input logic [31:0] w, input logic [2:0] bc, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, bc, w};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Drain all hashes, then let the unit finish any stripe still in flight
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        // let the checker count the beat taken at this edge
        @(posedge aclk);
        while (hashes_due != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed random message, with dropped short words and oversized counts
    task automatic send_message(input int nbytes);
        int       nwords;
        int       rem;
        logic [2:0] bc;
        nwords = nbytes / 4;
        rem    = nbytes % 4;
        if (nbytes == 0) begin
            send_beat($urandom, 3'd0, 1'b1);
            beats_sent++;
        end else begin
            for (int i = 0; i < nwords; i++) begin
                if ($urandom_range(19) == 0)
                    send_beat($urandom, 3'($urandom_range(3)), 1'b0);
                bc = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
                send_beat($urandom, bc, (rem == 0) && (i == nwords - 1));
                beats_sent++;
            end
            if (rem != 0) begin
                send_beat($urandom, 3'(rem), 1'b1);
                beats_sent++;
            end
        end
    endtask

    initial begin
        int target;
        int pick;
        int nbytes;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty message under the reset seed, then under the all-ones seed
        send_beat(32'h0, 3'd0, 1'b1);
        wait_quiet();
        write_seed(32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 3'd0, 1'b1);

        // Byte tails with junk in the unused bytes, and one full final word
        send_beat(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_beat(32'hFFFF_FFFF, 3'd2, 1'b1);
        send_beat(32'hFFFF_FFFF, 3'd3, 1'b1);
        send_beat(32'h0000_0000, 3'd4, 1'b1);

        // Final word closes a stripe
        repeat (3) send_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);

        // Oversized counts count as four; short non-final words are dropped
        send_beat(32'hA5A5_5A5A, 3'd7, 1'b0);
        send_beat(32'h1234_5678, 3'd1, 1'b0);
        send_beat(32'h8000_0001, 3'd4, 1'b0);
        send_beat(32'hDEAD_BEEF, 3'd0, 1'b0);
        send_beat(32'h7FFF_FFFE, 3'd5, 1'b1);

        // Seed change before any stripe: lanes reload
        send_beat($urandom, 3'd4, 1'b0);
        send_beat($urandom, 3'd4, 1'b0);
        wait_quiet();
        write_seed(32'h1234_5678);
        repeat (3) send_beat($urandom, 3'd4, 1'b0);
        send_beat($urandom, 3'd2, 1'b1);

        // Seed change after a stripe: lanes keep their values
        repeat (5) send_beat($urandom, 3'd4, 1'b0);
        wait_quiet();
        write_seed(32'h0);
        send_beat($urandom, 3'd3, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            wait_quiet();
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  write_seed(32'h0);         end
                1: begin send_idle = 86; recv_stall = 0;  write_seed(32'hFFFF_FFFF); end
                2: begin send_idle = 0;  recv_stall = 86; write_seed($urandom);      end
                default: begin send_idle = 21; recv_stall = 21; write_seed($urandom); end
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    nbytes = $urandom_range(20);
                else if (pick < 95)
                    nbytes = $urandom_range(80, 21);
                else
                    nbytes = $urandom_range(300, 81);
                send_message(nbytes);
            end
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/xxh32_pkg.sv
hw/rtl/xxh32_alu.sv
hw/rtl/xxhash32_stream_unit.sv
hw/rtl/xxh32_chk.sv
bench/xxh32_hash_checker.sv
bench/tb_xxhash32_stream_unit.sv
